>>> rtl/tad_pkg.sv
package tad_pkg;

	// sample width of the light sensor converter
	localparam int SAMPLE_BITS = 12;

	// stream payload layout
	localparam int IN_BITS        = SAMPLE_BITS + 32;
	localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS       = SAMPLE_BITS + 3;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// register file
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_SENSOR_ENABLED  = 3'd0,
		REG_DARK_THRESHOLD  = 3'd1,
		REG_ACTIVE_DB_EN    = 3'd2,
		REG_ACTIVE_DB_MS    = 3'd3,
		REG_INACTIVE_DB_EN  = 3'd4,
		REG_INACTIVE_DB_MS  = 3'd5
	} reg_idx_t;

	localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(2048);

	typedef struct packed {
		logic                   sensor_enabled;
		logic [SAMPLE_BITS-1:0] dark_threshold;
		logic                   active_db_en;
		logic [15:0]            active_db_ms;
		logic                   inactive_db_en;
		logic [15:0]            inactive_db_ms;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] captured_sample;
		logic                   level_known;
		logic                   level_active;
		logic                   changed;
	} result_t;

endpackage

>>> rtl/tad_cfg.sv
module tad_cfg
	import tad_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enabled <= 1'b0;
			cfg_q.dark_threshold <= THRESHOLD_RESET;
			cfg_q.active_db_en   <= 1'b0;
			cfg_q.active_db_ms   <= '0;
			cfg_q.inactive_db_en <= 1'b0;
			cfg_q.inactive_db_ms <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SENSOR_ENABLED: cfg_q.sensor_enabled <= pwdata[0];
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= SAMPLE_BITS'(pwdata[11:0]);
				REG_ACTIVE_DB_EN:   cfg_q.active_db_en   <= pwdata[0];
				REG_ACTIVE_DB_MS:   cfg_q.active_db_ms   <= pwdata[15:0];
				REG_INACTIVE_DB_EN: cfg_q.inactive_db_en <= pwdata[0];
				REG_INACTIVE_DB_MS: cfg_q.inactive_db_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SENSOR_ENABLED: prdata = DATA_BITS'(cfg_q.sensor_enabled);
			REG_DARK_THRESHOLD: prdata = DATA_BITS'(cfg_q.dark_threshold);
			REG_ACTIVE_DB_EN:   prdata = DATA_BITS'(cfg_q.active_db_en);
			REG_ACTIVE_DB_MS:   prdata = DATA_BITS'(cfg_q.active_db_ms);
			REG_INACTIVE_DB_EN: prdata = DATA_BITS'(cfg_q.inactive_db_en);
			REG_INACTIVE_DB_MS: prdata = DATA_BITS'(cfg_q.inactive_db_ms);
			default:            prdata = '0;
		endcase
	end

endmodule

>>> rtl/tad_core.sv
module tad_core
	import tad_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [31:0]            now_ms,
	input  cfg_t                   cfg,
	output result_t                res
);

	logic                   known_valid_q;
	logic                   known_level_q;
	logic                   in_debounce_q;
	logic                   candidate_q;
	logic [31:0]            start_ms_q;
	logic [SAMPLE_BITS-1:0] held_sample_q;
	result_t                res_s2;

	logic                   known_valid_d;
	logic                   known_level_d;
	logic                   in_debounce_d;
	logic                   candidate_d;
	logic [31:0]            start_ms_d;
	logic [SAMPLE_BITS-1:0] held_sample_d;
	logic                   changed;

	logic        level;
	logic        same;
	logic [31:0] elapsed;
	logic [15:0] need;

	assign level = (sample < cfg.dark_threshold);
	assign same  = known_valid_q && (known_level_q == level);

	// next state for one item
	always_comb begin
		known_valid_d = known_valid_q;
		known_level_d = known_level_q;
		in_debounce_d = in_debounce_q;
		candidate_d   = candidate_q;
		start_ms_d    = start_ms_q;
		held_sample_d = held_sample_q;
		changed       = 1'b0;
		elapsed       = '0;
		need          = '0;
		if (cfg.sensor_enabled) begin
			if (!cfg.active_db_en && !cfg.inactive_db_en) begin
				// immediate mode, no capture
				if (!same) begin
					known_valid_d = 1'b1;
					known_level_d = level;
					changed       = 1'b1;
				end
			end else if (in_debounce_q || !same) begin
				// debounce window: a fresh one starts at this item unless one is already open
				if (!in_debounce_q) begin
					start_ms_d  = now_ms;
					candidate_d = level;
				end
				elapsed = now_ms - start_ms_d;
				if (level) begin
					need = cfg.active_db_en ? cfg.active_db_ms : 16'd0;
				end else begin
					need = cfg.inactive_db_en ? cfg.inactive_db_ms : 16'd0;
				end
				in_debounce_d = 1'b1;
				if (level != candidate_d) begin
					in_debounce_d = 1'b0;
				end else if (elapsed >= {16'd0, need}) begin
					in_debounce_d = 1'b0;
					if (!same) begin
						known_valid_d = 1'b1;
						known_level_d = level;
						held_sample_d = sample;
						changed       = 1'b1;
					end
				end
			end
		end
	end

	// debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_valid_q <= 1'b0;
			known_level_q <= 1'b0;
			in_debounce_q <= 1'b0;
			candidate_q   <= 1'b0;
			start_ms_q    <= '0;
			held_sample_q <= '0;
		end else if (adv) begin
			known_valid_q <= known_valid_d;
			known_level_q <= known_level_d;
			in_debounce_q <= in_debounce_d;
			candidate_q   <= candidate_d;
			start_ms_q    <= start_ms_d;
			held_sample_q <= held_sample_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.changed         <= changed;
			res_s2.level_active    <= known_valid_d & known_level_d;
			res_s2.level_known     <= known_valid_d;
			res_s2.captured_sample <= held_sample_d;
		end
	end

	assign res = res_s2;

endmodule

>>> rtl/threshold_asymmetric_debouncer.sv
// each accepted item passes the input register, then the result register
// throughput: one item per cycle while m_axis is not stalled, set by the
// combinational compare and elapsed-time subtract updating the debounce state
// reset: arst_n clears the pipeline valids, the debounce state and the
// registers to their defaults (threshold 2048, all else zero)
module threshold_asymmetric_debouncer
	import tad_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_BITS-1:0]      paddr,
	input  logic [DATA_BITS-1:0]      pwdata,
	output logic [DATA_BITS-1:0]      prdata,
	output logic                      pready,
	// input items
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // adc_sample, now_ms, zero pad
	// result items
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata   // changed, level_active,
	                                                 // level_known, captured_sample,
	                                                 // zero pad
);

	cfg_t                   cfg;
	result_t                res;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [31:0]            now_s1;
	logic                   valid_s2;
	logic                   out_free;
	logic                   adv;
	logic                   in_fire;

	tad_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake chain
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
			now_s1    <= s_axis_tdata[SAMPLE_BITS +: 32];
		end
	end

	tad_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.sample (sample_s1),
		.now_ms (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_BITS'(res);

endmodule
